### rtl/core/multi_tap_keypad_text_entry_macros.svh
// Assertion helpers used by the keypad text entry top module.
`ifndef MULTI_TAP_KEYPAD_TEXT_ENTRY_MACROS_SVH
`define MULTI_TAP_KEYPAD_TEXT_ENTRY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mtk_pkg.sv
package mtk_pkg;

    localparam logic [2:0] CMD_KEY    = 3'd0;
    localparam logic [2:0] CMD_DEL    = 3'd1;
    localparam logic [2:0] CMD_CLEAR  = 3'd2;
    localparam logic [2:0] CMD_HIDE   = 3'd3;
    localparam logic [2:0] CMD_CURSOR = 3'd4;
    localparam logic [2:0] CMD_TICK   = 3'd5;

    localparam logic [3:0]  NO_KEY        = 4'd10;
    localparam logic [3:0]  MAX_KEY       = 4'd9;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // Character sequence of each key, digit first.
    localparam logic [7:0] SEQ_TAB [10][9] = '{
        '{8'h30, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h32, 8'h61, 8'h62, 8'h63, 8'hE4, 8'h41, 8'h42, 8'h43, 8'hC4},
        '{8'h33, 8'h64, 8'h65, 8'h66, 8'h44, 8'h45, 8'h46, 8'h00, 8'h00},
        '{8'h34, 8'h67, 8'h68, 8'h69, 8'h47, 8'h48, 8'h49, 8'h00, 8'h00},
        '{8'h35, 8'h6A, 8'h6B, 8'h6C, 8'h4A, 8'h4B, 8'h4C, 8'h00, 8'h00},
        '{8'h36, 8'h6D, 8'h6E, 8'h6F, 8'hF6, 8'h4D, 8'h4E, 8'h4F, 8'hD6},
        '{8'h37, 8'h70, 8'h71, 8'h72, 8'h73, 8'h50, 8'h51, 8'h52, 8'h53},
        '{8'h38, 8'h74, 8'h75, 8'h76, 8'hFC, 8'h54, 8'h55, 8'h56, 8'hDC},
        '{8'h39, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h57, 8'h58, 8'h59, 8'h5A}
    };

    // Sequence length of a key.
    function automatic logic [3:0] seq_len(input logic [3:0] key);
        logic [3:0] len;
        case (key)
            4'd0:                   len = 4'd2;
            4'd1:                   len = 4'd1;
            4'd3, 4'd4, 4'd5:       len = 4'd7;
            default:                len = 4'd9;
        endcase
        return len;
    endfunction

    // Buffer operation issued by the entry control.
    typedef struct packed {
        logic       wr_en;
        logic       replace;
        logic       del;
        logic       clr;
        logic [7:0] wr_char;
    } t_text_op;

    // Buffer status seen by the entry control.
    typedef struct packed {
        logic full;
        logic empty;
    } t_buf_stat;

    // Flags after the update.
    typedef struct packed {
        logic masked;
        logic cursor;
        logic open;
    } t_flags;

endpackage

### rtl/core/mtk_in_if.sv
interface mtk_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [3:0] key;
    logic       hide;
    logic [3:0] read_index;

    modport source (output valid, cmd, key, hide, read_index, input ready);
    modport sink   (input valid, cmd, key, hide, read_index, output ready);
endinterface

### rtl/core/mtk_out_if.sv
interface mtk_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] text_length;
    logic [7:0] read_char;
    logic       text_hidden;
    logic       cursor_shown;
    logic       entry_open;

    modport source (output valid, text_length, read_char, text_hidden, cursor_shown,
                    entry_open, input ready);
    modport sink   (input valid, text_length, read_char, text_hidden, cursor_shown,
                    entry_open, output ready);
endinterface

### rtl/core/multi_tap_keypad_text_entry.sv
// Multi-tap keypad text entry.
// Command channel (i_cmd_ch): one transaction per event - key press, delete last,
// clear, set hide, cursor toggle or timer tick - plus the buffer position to report.
// Result channel (o_res_ch): exactly one transaction per command transaction, carrying
// the text length, the character at the requested position (0 past the end), and the
// hidden, cursor and open-entry flags as they stand after that command.
// Configuration: i_cfg_wr_en / i_cfg_wr_data write the entry timeout in ticks; write
// only while no transaction is in flight.
// Result: registered, and valid in the cycle after the command is accepted.
// Throughput: one command per cycle while results are taken; the whole update is a
// table lookup and flag logic between the state registers and the result register.
// Stall: the result register holds while the receiver is not ready; a new command is
// accepted in the same cycle the held result is taken.
// Reset (synchronous, active low): empty buffer, no open entry, timer stopped,
// flags cleared, timeout back to 1000 ticks, no result pending.
`include "multi_tap_keypad_text_entry_macros.svh"

module multi_tap_keypad_text_entry #(
    parameter int TEXT_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mtk_in_if.sink       i_cmd_ch,
    mtk_out_if.source    o_res_ch,
    input  logic         i_cfg_wr_en,
    input  logic [15:0]  i_cfg_wr_data
);
    import mtk_pkg::*;

    localparam int CW = $clog2(TEXT_DEPTH + 1);

    logic          w_accept;
    t_text_op      w_op;
    t_buf_stat     w_stat;
    t_flags        w_flags;
    logic [CW-1:0] w_count_next;
    logic [7:0]    w_read_char;

    logic          r_out_valid;
    logic [4:0]    r_len;
    logic          r_hidden;
    logic          r_cursor;
    logic          r_open;

    // Take a new command whenever the result register is free or being drained.
    assign i_cmd_ch.ready = !r_out_valid || o_res_ch.ready;
    assign w_accept       = i_cmd_ch.valid && i_cmd_ch.ready;

    mtk_entry_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_cmd         (i_cmd_ch.cmd),
        .i_key         (i_cmd_ch.key),
        .i_hide        (i_cmd_ch.hide),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stat        (w_stat),
        .o_op          (w_op),
        .o_flags       (w_flags)
    );

    mtk_text_buf #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_op         (w_op),
        .i_read_index (i_cmd_ch.read_index),
        .o_stat       (w_stat),
        .o_count_next (w_count_next),
        .o_read_char  (w_read_char)
    );

    // Result register: load on accept, drop valid once taken, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len    <= 5'(w_count_next);
            r_hidden <= w_flags.masked;
            r_cursor <= w_flags.cursor;
            r_open   <= w_flags.open;
        end
    end

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.text_length  = r_len;
    assign o_res_ch.read_char    = w_read_char;
    assign o_res_ch.text_hidden  = r_hidden;
    assign o_res_ch.cursor_shown = r_cursor;
    assign o_res_ch.entry_open   = r_open;

    `MTK_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_res_ch.ready, !i_cmd_ch.ready, "command taken while result stalled")
    `MTK_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, w_accept, r_out_valid, "accepted command produced no result")
    `MTK_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, r_out_valid, int'(r_len) <= TEXT_DEPTH, "text length beyond buffer depth")

endmodule

### rtl/core/mtk_entry_ctrl.sv
module mtk_entry_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_cmd,
    input  logic [3:0]        i_key,
    input  logic              i_hide,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  mtk_pkg::t_buf_stat i_stat,
    output mtk_pkg::t_text_op  o_op,
    output mtk_pkg::t_flags    o_flags
);
    import mtk_pkg::*;

    logic [15:0] r_timeout;
    logic [3:0]  r_last_key, n_last_key;
    logic [3:0]  r_press_cnt, n_press_cnt;
    logic        r_append, n_append;
    logic        r_masked, n_masked;
    logic        r_cursor, n_cursor;
    logic        r_tmr_run, n_tmr_run;
    logic [15:0] r_tmr_cnt, n_tmr_cnt;

    logic        w_same;
    logic        w_app;
    logic [3:0]  w_len;
    logic [3:0]  w_pos;
    logic [15:0] w_limit;

    always_comb begin
        n_last_key  = r_last_key;
        n_press_cnt = r_press_cnt;
        n_append    = r_append;
        n_masked    = r_masked;
        n_cursor    = r_cursor;
        n_tmr_run   = r_tmr_run;
        n_tmr_cnt   = r_tmr_cnt;
        o_op        = '0;
        w_same      = (i_key == r_last_key);
        w_app       = !w_same || (i_key <= 4'd1) || r_append;
        w_len       = seq_len(i_key);
        w_pos       = w_same ? (r_press_cnt + 4'd1) : 4'd1;
        if (w_pos > w_len) begin
            w_pos = 4'd1;
        end
        w_limit     = (r_timeout == '0) ? 16'd1 : r_timeout;

        unique case (i_cmd)
            CMD_KEY: begin
                if (i_key <= MAX_KEY && !i_stat.full) begin
                    n_masked    = 1'b0;
                    n_press_cnt = (w_pos == w_len) ? 4'd0 : w_pos;
                    n_last_key  = i_key;
                    n_tmr_run   = 1'b1;
                    n_tmr_cnt   = '0;
                    n_append    = 1'b0;
                    o_op.wr_en   = 1'b1;
                    o_op.replace = !w_app && !i_stat.empty;
                    o_op.wr_char = SEQ_TAB[i_key][w_pos - 4'd1];
                end
            end
            CMD_DEL: begin
                o_op.del = 1'b1;
                n_masked = 1'b0;
            end
            CMD_CLEAR: begin
                o_op.clr = 1'b1;
            end
            CMD_HIDE: begin
                n_masked = i_hide;
            end
            CMD_CURSOR: begin
                n_cursor = !(r_cursor || !r_append);
            end
            CMD_TICK: begin
                if (r_tmr_run) begin
                    n_tmr_cnt = r_tmr_cnt + 16'd1;
                    if (n_tmr_cnt >= w_limit) begin
                        n_tmr_run   = 1'b0;
                        n_press_cnt = 4'd0;
                        n_last_key  = NO_KEY;
                        n_append    = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        o_flags.masked = n_masked;
        o_flags.cursor = n_cursor;
        o_flags.open   = !n_append && n_last_key >= 4'd2 && n_last_key <= MAX_KEY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_last_key  <= NO_KEY;
            r_press_cnt <= '0;
            r_append    <= 1'b1;
            r_masked    <= 1'b0;
            r_cursor    <= 1'b0;
            r_tmr_run   <= 1'b0;
            r_tmr_cnt   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_last_key  <= n_last_key;
                r_press_cnt <= n_press_cnt;
                r_append    <= n_append;
                r_masked    <= n_masked;
                r_cursor    <= n_cursor;
                r_tmr_run   <= n_tmr_run;
                r_tmr_cnt   <= n_tmr_cnt;
            end
        end
    end

endmodule

### rtl/core/mtk_text_buf.sv
module mtk_text_buf #(
    parameter int TEXT_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  mtk_pkg::t_text_op  i_op,
    input  logic [3:0]         i_read_index,
    output mtk_pkg::t_buf_stat o_stat,
    output logic [$clog2(TEXT_DEPTH+1)-1:0] o_count_next,
    output logic [7:0]         o_read_char
);
    import mtk_pkg::*;

    localparam int CW = $clog2(TEXT_DEPTH + 1);
    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

    logic [7:0]    r_mem [TEXT_DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_pos;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_rd_ok;

    assign o_stat.full  = (r_count == CW'(TEXT_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        w_pos   = i_op.replace ? (r_count - CW'(1)) : r_count;
        if (i_op.wr_en) begin
            n_count = w_pos + CW'(1);
        end else if (i_op.del) begin
            if (r_count != '0) begin
                n_count = r_count - CW'(1);
            end
        end else if (i_op.clr) begin
            n_count = '0;
        end
    end

    assign o_count_next = n_count;
    assign w_wr_addr    = AW'(w_pos);
    assign w_rd_addr    = AW'(i_read_index);
    assign w_rd_ok      = (int'(i_read_index) < int'(n_count)) &&
                          (int'(i_read_index) < TEXT_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    // Store and read port; forward the character written in the same transaction.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (i_op.wr_en) begin
                r_mem[w_wr_addr] <= i_op.wr_char;
            end
            if (!w_rd_ok) begin
                o_read_char <= 8'h00;
            end else if (i_op.wr_en && w_wr_addr == w_rd_addr) begin
                o_read_char <= i_op.wr_char;
            end else begin
                o_read_char <= r_mem[w_rd_addr];
            end
        end
    end

endmodule
